FILE: src/nearest_free_tile_assigner_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef NEAREST_FREE_TILE_ASSIGNER_MACROS_SVH
`define NEAREST_FREE_TILE_ASSIGNER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define NFTA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define NFTA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/nfta_pkg.sv
// shared widths, types and constants of the nearest free tile assigner
// no dependencies
`default_nettype none

package nfta_pkg;

  localparam int ID_W       = 4;
  localparam int POS_W      = 15;
  localparam int TILE_OUT_W = 12;
  localparam int CNT_OUT_W  = 12;

  // agent id widened so any agent table index width can be cut from it
  localparam int ID_EXT_W   = 7;

  // offsets from tile centers, squares and sums over the full parameter range
  localparam int DIF_W      = 18;
  localparam int PRD_W      = 2 * DIF_W;
  localparam int DSQ_W      = 34;

  // (3 m in 1/32 m units) squared
  localparam int REACH_SQ   = 9216;

  // tile map entry: covered and assigned flags
  localparam int MAP_W      = 2;
  localparam int MAP_COV    = 1;
  localparam int MAP_ASG    = 0;

  typedef logic [ID_W-1:0]         id_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [DIF_W-1:0] dif_t;
  typedef logic signed [PRD_W-1:0] prd_t;
  typedef logic [DSQ_W-1:0]        dsq_t;

endpackage

`default_nettype wire

FILE: src/nfta_if.sv
// valid/ready channel interfaces for report beats and result beats
// depends on nfta_pkg
`default_nettype none

interface nfta_in_if;
  logic            valid;
  logic            ready;
  nfta_pkg::id_t   agent_id;
  nfta_pkg::pos_t  pos_x;
  nfta_pkg::pos_t  pos_y;

  modport source (output valid, output agent_id, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input agent_id, input pos_x, input pos_y, output ready);
endinterface

interface nfta_out_if;
  logic                                valid;
  logic                                ready;
  nfta_pkg::id_t                       agent_out;
  logic                                mission_done;
  logic                                tile_reached;
  logic                                newly_assigned;
  logic                                has_task;
  logic [nfta_pkg::TILE_OUT_W-1:0]     tile_index;
  logic [nfta_pkg::CNT_OUT_W-1:0]      covered_count;

  modport source (output valid, output agent_out, output mission_done, output tile_reached,
                  output newly_assigned, output has_task, output tile_index,
                  output covered_count, input ready);
  modport sink   (input valid, input agent_out, input mission_done, input tile_reached,
                  input newly_assigned, input has_task, input tile_index,
                  input covered_count, output ready);
endinterface

`default_nettype wire

FILE: src/nfta_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module nfta_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/nfta_mul.sv
// shared signed multiplier with a registered product
// depends on nfta_pkg
`default_nettype none

module nfta_mul (
  input  wire logic          clk,
  input  wire nfta_pkg::dif_t a,
  input  wire nfta_pkg::dif_t b,
  output nfta_pkg::prd_t     prod_r
);

  nfta_pkg::prd_t prod_nxt;

  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

FILE: src/nearest_free_tile_assigner.sv
// Nearest free tile assigner. Takes one agent position report per beat and returns one
// result beat. After reset the tile map is swept clear, one tile per cycle; no report is
// taken meanwhile. The scan reads one tile map entry per cycle through the map ram's read
// port and steps the squared distance by additions. Before the scan, the single shared
// multiplier forms the starting squares and cross terms. A report whose agent holds no
// tile, or whose held tile is reached, goes through the scan; a report that only checks a
// held tile goes through the reach check alone, and an ignored or mission-complete report
// goes straight to the result. One report is worked on at a time. The result sits in an
// output register, and a result still waiting there holds the block in its last step.
// The next report is taken from the cycle after the result is loaded.
// Depends on nfta_pkg, nfta_if, nfta_ram and nfta_mul.
`default_nettype none

module nearest_free_tile_assigner #(
  parameter int GRID_SIDE   = 50,
  parameter int TILE_SIZE_M = 10,
  parameter int MAX_AGENTS  = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nfta_in_if.sink     in_ch,
  nfta_out_if.source  out_ch
);

  localparam int TILE_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W      = $clog2(TILE_COUNT);
  localparam int CNT_W      = $clog2(TILE_COUNT + 1);
  localparam int SIDE_W     = $clog2(GRID_SIDE);
  localparam int AG_W       = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int TASK_W     = IDX_W + 2 * SIDE_W;
  localparam int STEP       = 32 * TILE_SIZE_M;
  localparam int STEP2      = 2 * STEP;
  localparam int STEP_SQ    = STEP * STEP;
  localparam int STEP_SQ2   = 2 * STEP_SQ;
  localparam int CTR_OFF    = 16 * TILE_SIZE_M * (GRID_SIDE - 1);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_TASK   = 4'd2;
  localparam logic [3:0] ST_RPREP  = 4'd3;
  localparam logic [3:0] ST_RX     = 4'd4;
  localparam logic [3:0] ST_RY     = 4'd5;
  localparam logic [3:0] ST_RCHK   = 4'd6;
  localparam logic [3:0] ST_SX1    = 4'd7;
  localparam logic [3:0] ST_SX2    = 4'd8;
  localparam logic [3:0] ST_SY1    = 4'd9;
  localparam logic [3:0] ST_SY2    = 4'd10;
  localparam logic [3:0] ST_SGO    = 4'd11;
  localparam logic [3:0] ST_SCAN   = 4'd12;
  localparam logic [3:0] ST_DRAIN  = 4'd13;
  localparam logic [3:0] ST_ASSIGN = 4'd14;
  localparam logic [3:0] ST_FIN    = 4'd15;

  logic [3:0]              state_r, state_nxt;

  // report
  nfta_pkg::id_t           id_r;
  logic                    id_ok_r;
  logic                    done_r;
  nfta_pkg::dif_t          dx0_r, dy0_r;
  nfta_pkg::dif_t          dx0_nxt, dy0_nxt;

  // held tile
  logic                    hold_r;
  logic [IDX_W-1:0]        hold_idx_r;
  logic [SIDE_W-1:0]       t_col_r, t_row_r;
  nfta_pkg::dif_t          dx_r, dy_r;
  nfta_pkg::dsq_t          acc_r;
  logic                    reached_r;
  logic                    assigned_r;

  // scan stepping
  nfta_pkg::prd_t          sqx0_r, ex0_r, sqx_r, ex_r, sqy_r, ey_r;
  logic [SIDE_W-1:0]       col_r, row_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    p_valid_r;
  nfta_pkg::dsq_t          p_dist_r;
  logic [IDX_W-1:0]        p_idx_r;
  logic [SIDE_W-1:0]       p_col_r, p_row_r;
  logic                    found_r;
  nfta_pkg::dsq_t          best_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [SIDE_W-1:0]       best_col_r, best_row_r;

  logic [MAX_AGENTS-1:0]   task_valid_r;
  logic [CNT_W-1:0]        cov_cnt_r;

  // output register
  logic                    out_valid_r;
  nfta_pkg::id_t           o_agent_r;
  logic                    o_done_r, o_reached_r, o_assigned_r, o_has_r;
  logic [nfta_pkg::TILE_OUT_W-1:0] o_tile_r;
  logic [nfta_pkg::CNT_OUT_W-1:0]  o_cnt_r;

  // shared multiplier
  nfta_pkg::dif_t          mul_a, mul_b;
  nfta_pkg::prd_t          prod_r;

  // rams
  logic                    map_we;
  logic [IDX_W-1:0]        map_waddr;
  logic [nfta_pkg::MAP_W-1:0] map_wdata, map_rdata;
  logic                    task_we;
  logic [AG_W-1:0]         task_raddr;
  logic [TASK_W-1:0]       task_rdata, task_wdata;

  logic [nfta_pkg::ID_EXT_W-1:0] in_id_ext, id_ext;
  logic [AG_W-1:0]         id_idx;
  logic                    in_acc, out_free, tv;
  nfta_pkg::dsq_t          reach_sum;
  logic                    reach_hit;
  localparam int DIF_W_L = nfta_pkg::DIF_W;
  logic [DIF_W_L-1:0]      stepc_x, stepc_y;
  logic                    scan_last, col_last, map_free, better;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_id_ext = nfta_pkg::ID_EXT_W'(in_ch.agent_id);
  assign id_ext    = nfta_pkg::ID_EXT_W'(id_r);
  assign id_idx    = id_ext[AG_W-1:0];
  assign task_raddr = in_id_ext[AG_W-1:0];
  assign tv        = id_ok_r && task_valid_r[id_idx];

  assign dx0_nxt = nfta_pkg::DIF_W'(in_ch.pos_x) + nfta_pkg::DIF_W'(CTR_OFF);
  assign dy0_nxt = nfta_pkg::DIF_W'(in_ch.pos_y) + nfta_pkg::DIF_W'(CTR_OFF);

  assign stepc_x = DIF_W_L'(STEP) * DIF_W_L'(t_col_r);
  assign stepc_y = DIF_W_L'(STEP) * DIF_W_L'(t_row_r);

  assign reach_sum = acc_r + prod_r[nfta_pkg::DSQ_W-1:0];
  assign reach_hit = reach_sum < nfta_pkg::DSQ_W'(nfta_pkg::REACH_SQ);

  assign scan_last = idx_r == IDX_W'(TILE_COUNT - 1);
  assign col_last  = col_r == SIDE_W'(GRID_SIDE - 1);
  assign map_free  = map_rdata == '0;
  assign better    = !found_r || (p_dist_r < best_r);

  assign in_ch.ready = state_r == ST_IDLE;

  // multiplier operand select
  always_comb begin
    case (state_r)
      ST_RX: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      ST_RY: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
      ST_SX1: begin
        mul_a = dx0_r;
        mul_b = dx0_r;
      end
      ST_SX2: begin
        mul_a = dx0_r;
        mul_b = nfta_pkg::DIF_W'(STEP2);
      end
      ST_SY1: begin
        mul_a = dy0_r;
        mul_b = dy0_r;
      end
      ST_SY2: begin
        mul_a = dy0_r;
        mul_b = nfta_pkg::DIF_W'(STEP2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // tile map writes: clearing sweep, covered mark, new assignment
  always_comb begin
    map_we    = 1'b0;
    map_waddr = idx_r;
    map_wdata = '0;
    case (state_r)
      ST_CLEAR: begin
        map_we = 1'b1;
      end
      ST_RCHK: begin
        map_we    = reach_hit;
        map_waddr = hold_idx_r;
        map_wdata[nfta_pkg::MAP_COV] = 1'b1;
        map_wdata[nfta_pkg::MAP_ASG] = 1'b1;
      end
      ST_ASSIGN: begin
        map_we    = found_r;
        map_waddr = best_idx_r;
        map_wdata[nfta_pkg::MAP_ASG] = 1'b1;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  assign task_we    = (state_r == ST_ASSIGN) && found_r;
  assign task_wdata = {best_row_r, best_col_r, best_idx_r};

  always_comb begin
    case (state_r)
      ST_CLEAR:  state_nxt = scan_last ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_nxt = in_acc ? ST_TASK : ST_IDLE;
      ST_TASK: begin
        if (!id_ok_r || done_r) begin
          state_nxt = ST_FIN;
        end else if (tv) begin
          state_nxt = ST_RPREP;
        end else begin
          state_nxt = ST_SX1;
        end
      end
      ST_RPREP:  state_nxt = ST_RX;
      ST_RX:     state_nxt = ST_RY;
      ST_RY:     state_nxt = ST_RCHK;
      ST_RCHK:   state_nxt = reach_hit ? ST_SX1 : ST_FIN;
      ST_SX1:    state_nxt = ST_SX2;
      ST_SX2:    state_nxt = ST_SY1;
      ST_SY1:    state_nxt = ST_SY2;
      ST_SY2:    state_nxt = ST_SGO;
      ST_SGO:    state_nxt = ST_SCAN;
      ST_SCAN:   state_nxt = scan_last ? ST_DRAIN : ST_SCAN;
      ST_DRAIN:  state_nxt = ST_ASSIGN;
      ST_ASSIGN: state_nxt = ST_FIN;
      ST_FIN:    state_nxt = out_free ? ST_IDLE : ST_FIN;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      task_valid_r <= '0;
      cov_cnt_r    <= '0;
      p_valid_r    <= 1'b0;
      found_r      <= 1'b0;
      hold_r       <= 1'b0;
      reached_r    <= 1'b0;
      assigned_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= state_r == ST_SCAN;

      if (p_valid_r && map_free && better) begin
        found_r <= 1'b1;
      end

      case (state_r)
        ST_CLEAR: begin
          idx_r <= idx_r + IDX_W'(1);
        end
        ST_IDLE: begin
          reached_r  <= 1'b0;
          assigned_r <= 1'b0;
        end
        ST_TASK: begin
          hold_r <= tv;
        end
        ST_RCHK: begin
          if (reach_hit) begin
            reached_r            <= 1'b1;
            hold_r               <= 1'b0;
            task_valid_r[id_idx] <= 1'b0;
            cov_cnt_r            <= cov_cnt_r + CNT_W'(1);
          end
        end
        ST_SGO: begin
          idx_r   <= '0;
          found_r <= 1'b0;
        end
        ST_SCAN: begin
          idx_r <= idx_r + IDX_W'(1);
        end
        ST_ASSIGN: begin
          if (found_r) begin
            task_valid_r[id_idx] <= 1'b1;
            hold_r               <= 1'b1;
            assigned_r           <= 1'b1;
          end
        end
        default: begin
          idx_r <= idx_r;
        end
      endcase

      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r    <= in_ch.agent_id;
      id_ok_r <= int'(in_ch.agent_id) < MAX_AGENTS;
      done_r  <= cov_cnt_r >= CNT_W'(TILE_COUNT);
      dx0_r   <= dx0_nxt;
      dy0_r   <= dy0_nxt;
    end

    if (state_r == ST_TASK) begin
      hold_idx_r <= task_rdata[IDX_W-1:0];
      t_col_r    <= task_rdata[IDX_W+SIDE_W-1:IDX_W];
      t_row_r    <= task_rdata[TASK_W-1:IDX_W+SIDE_W];
    end

    if (state_r == ST_RPREP) begin
      dx_r <= dx0_r - $signed(stepc_x);
      dy_r <= dy0_r - $signed(stepc_y);
    end

    if (state_r == ST_RY) begin
      acc_r <= prod_r[nfta_pkg::DSQ_W-1:0];
    end

    // starting squares and cross terms from the shared multiplier
    if (state_r == ST_SX2) begin
      sqx0_r <= prod_r;
    end
    if (state_r == ST_SY1) begin
      ex0_r <= prod_r;
    end
    if (state_r == ST_SY2) begin
      sqy_r <= prod_r;
    end
    if (state_r == ST_SGO) begin
      ey_r  <= prod_r;
      sqx_r <= sqx0_r;
      ex_r  <= ex0_r;
      col_r <= '0;
      row_r <= '0;
    end

    // (d - s)^2 = d^2 - 2sd + s^2, with 2sd kept as a running term
    if (state_r == ST_SCAN) begin
      p_dist_r <= sqx_r[nfta_pkg::DSQ_W-1:0] + sqy_r[nfta_pkg::DSQ_W-1:0];
      p_idx_r  <= idx_r;
      p_col_r  <= col_r;
      p_row_r  <= row_r;
      if (col_last) begin
        col_r <= '0;
        row_r <= row_r + SIDE_W'(1);
        sqx_r <= sqx0_r;
        ex_r  <= ex0_r;
        sqy_r <= sqy_r - ey_r + nfta_pkg::PRD_W'(STEP_SQ);
        ey_r  <= ey_r - nfta_pkg::PRD_W'(STEP_SQ2);
      end else begin
        col_r <= col_r + SIDE_W'(1);
        sqx_r <= sqx_r - ex_r + nfta_pkg::PRD_W'(STEP_SQ);
        ex_r  <= ex_r - nfta_pkg::PRD_W'(STEP_SQ2);
      end
    end

    // compare stage lines up with the registered map read
    if (p_valid_r && map_free && better) begin
      best_r     <= p_dist_r;
      best_idx_r <= p_idx_r;
      best_col_r <= p_col_r;
      best_row_r <= p_row_r;
    end

    if (state_r == ST_ASSIGN && found_r) begin
      hold_idx_r <= best_idx_r;
    end

    if (state_r == ST_FIN && out_free) begin
      o_agent_r    <= id_r;
      o_done_r     <= done_r;
      o_reached_r  <= reached_r;
      o_assigned_r <= assigned_r;
      o_has_r      <= hold_r;
      o_tile_r     <= hold_r ? nfta_pkg::TILE_OUT_W'(hold_idx_r) : '0;
      o_cnt_r      <= nfta_pkg::CNT_OUT_W'(cov_cnt_r);
    end
  end

  nfta_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  nfta_ram #(
    .WIDTH (nfta_pkg::MAP_W),
    .DEPTH (TILE_COUNT)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (idx_r),
    .rdata (map_rdata)
  );

  nfta_ram #(
    .WIDTH (TASK_W),
    .DEPTH (MAX_AGENTS)
  ) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (id_idx),
    .wdata (task_wdata),
    .raddr (task_raddr),
    .rdata (task_rdata)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.agent_out      = o_agent_r;
  assign out_ch.mission_done   = o_done_r;
  assign out_ch.tile_reached   = o_reached_r;
  assign out_ch.newly_assigned = o_assigned_r;
  assign out_ch.has_task       = o_has_r;
  assign out_ch.tile_index     = o_tile_r;
  assign out_ch.covered_count  = o_cnt_r;

endmodule

`default_nettype wire

FILE: src/nfta_chk.sv
// port-level checker for the nearest free tile assigner, bound to the top level
// depends on nfta_pkg and nearest_free_tile_assigner_macros.svh
`default_nettype none
`include "nearest_free_tile_assigner_macros.svh"

module nfta_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire nfta_pkg::id_t                   agent_out,
  input wire logic                            mission_done,
  input wire logic                            tile_reached,
  input wire logic                            newly_assigned,
  input wire logic                            has_task,
  input wire logic [nfta_pkg::TILE_OUT_W-1:0] tile_index,
  input wire logic [nfta_pkg::CNT_OUT_W-1:0]  covered_count
);

  // one report at a time: busy right after a report beat
  `NFTA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready after report beat")

  // a stalled result holds
  `NFTA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({agent_out, mission_done, tile_reached, newly_assigned, has_task, tile_index, covered_count}), "stalled result changed")

  // nothing happens once the mission is complete
  `NFTA_ASSERT_IMP(a_done_quiet, clk, rst_n, out_valid && mission_done, !tile_reached && !newly_assigned, "activity after mission complete")

  // no task means tile index reads zero
  `NFTA_ASSERT_IMP(a_idle_tile_zero, clk, rst_n, out_valid && !has_task, tile_index == '0, "tile index without task")

  // a fresh assignment leaves the agent holding it
  `NFTA_ASSERT_IMP(a_assign_holds, clk, rst_n, out_valid && newly_assigned, has_task, "assigned but no task held")

endmodule

bind nearest_free_tile_assigner nfta_chk u_nfta_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .agent_out      (out_ch.agent_out),
  .mission_done   (out_ch.mission_done),
  .tile_reached   (out_ch.tile_reached),
  .newly_assigned (out_ch.newly_assigned),
  .has_task       (out_ch.has_task),
  .tile_index     (out_ch.tile_index),
  .covered_count  (out_ch.covered_count)
);

`default_nettype wire

FILE: sim/nearest_free_tile_assigner_test.sv
// self-checking bench for the nearest free tile assigner: a queue-fed report driver,
// a result monitor and a tile dispatch predictor kept in step with accepted reports
// depends on nfta_pkg, nfta_if and the nearest_free_tile_assigner rtl
`default_nettype none

module nearest_free_tile_assigner_test;

  localparam int GRID        = 50;
  localparam int TILE_M      = 10;
  localparam int AGENTS      = 16;
  localparam int TILES       = GRID * GRID;
  localparam int HOLD_CYCLES = 6000;
  localparam int TAIL_CYCLES = 3000;
  localparam int PHASE_ITEMS = 52;
  localparam longint TIMEOUT_CYCLES = 4_000_000;

  typedef struct {
    nfta_pkg::id_t  agent;
    nfta_pkg::pos_t x;
    nfta_pkg::pos_t y;
  } report_t;

  typedef struct packed {
    nfta_pkg::id_t                   agent;
    logic                            done;
    logic                            reached;
    logic                            assigned;
    logic                            holds;
    logic [nfta_pkg::TILE_OUT_W-1:0] tile;
    logic [nfta_pkg::CNT_OUT_W-1:0]  count;
  } outcome_t;

  logic clk;
  logic rst_n;

  nfta_in_if  in_ch ();
  nfta_out_if out_ch ();

  nearest_free_tile_assigner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  bit tile_covered [TILES];
  bit tile_taken   [TILES];
  bit task_held    [AGENTS];
  int task_tile    [AGENTS];
  int covered_total;

  report_t  queued_reports [$];
  outcome_t pending_results [$];
  report_t  next_report;
  outcome_t got_result;
  outcome_t want_result;

  int reports_sent;
  int reports_taken;
  int results_seen;
  int reaches_seen;
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int holds_asked;
  int holds_done;

  int idle_mix  [4] = '{0, 80, 0, 24};
  int stall_mix [4] = '{0, 0, 80, 24};

  function automatic longint tile_center(input int k);
    return longint'(16 * TILE_M) * (2 * longint'(k) - GRID + 1);
  endfunction

  function automatic longint tile_dist2(input longint px, input longint py, input int t);
    longint dx;
    longint dy;
    dx = px - tile_center(t % GRID);
    dy = py - tile_center(t / GRID);
    return dx * dx + dy * dy;
  endfunction

  function automatic outcome_t predict_assignment(input report_t r);
    outcome_t o;
    longint   px;
    longint   py;
    longint   d;
    longint   best;
    int       id;
    int       pick;
    bit       found;
    px = longint'(r.x);
    py = longint'(r.y);
    id = int'(r.agent);
    o = '0;
    o.agent = r.agent;
    o.done = (covered_total >= TILES);
    if (id < AGENTS) begin
      if (!o.done) begin
        if (task_held[id] && task_tile[id] < TILES &&
            tile_dist2(px, py, task_tile[id]) < nfta_pkg::REACH_SQ) begin
          if (!tile_covered[task_tile[id]]) begin
            tile_covered[task_tile[id]] = 1'b1;
            covered_total++;
          end
          task_held[id] = 1'b0;
          o.reached = 1'b1;
        end
        if (!task_held[id]) begin
          found = 1'b0;
          best = 0;
          pick = 0;
          // nearest free tile, lowest index wins a tie
          for (int i = 0; i < TILES; i++) begin
            if (!tile_taken[i] && !tile_covered[i]) begin
              d = tile_dist2(px, py, i);
              if (!found || d < best) begin
                found = 1'b1;
                best = d;
                pick = i;
              end
            end
          end
          if (found) begin
            task_held[id] = 1'b1;
            task_tile[id] = pick;
            tile_taken[pick] = 1'b1;
            o.assigned = 1'b1;
          end
        end
      end
      if (task_held[id]) begin
        o.holds = 1'b1;
        o.tile = nfta_pkg::TILE_OUT_W'(task_tile[id]);
      end
    end
    o.count = nfta_pkg::CNT_OUT_W'(covered_total);
    return o;
  endfunction

  function automatic void flag_result(input string why, input outcome_t got,
                                      input outcome_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: got agent %0d done %0b reached %0b new %0b task %0b tile %0d cov %0d",
               $time, why, got.agent, got.done, got.reached, got.assigned, got.holds,
               got.tile, got.count);
      $display("  expected agent %0d done %0b reached %0b new %0b task %0b tile %0d cov %0d",
               want.agent, want.done, want.reached, want.assigned, want.holds,
               want.tile, want.count);
    end
  endfunction

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.agent_id = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    out_ch.ready = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("status: fail");
    $finish;
  end

  // report driver: a beat is held until taken, then the next one may follow
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        next_report.agent = in_ch.agent_id;
        next_report.x = in_ch.pos_x;
        next_report.y = in_ch.pos_y;
        pending_results = {pending_results, predict_assignment(next_report)};
        reports_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (queued_reports.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_report = queued_reports.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.agent_id <= next_report.agent;
          in_ch.pos_x <= next_report.x;
          in_ch.pos_y <= next_report.y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_result = '{out_ch.agent_out, out_ch.mission_done, out_ch.tile_reached,
                       out_ch.newly_assigned, out_ch.has_task, out_ch.tile_index,
                       out_ch.covered_count};
        results_seen++;
        if (got_result.reached === 1'b1) reaches_seen++;
        if (pending_results.size() == 0) begin
          flag_result("result beat with nothing pending", got_result, '0);
        end else begin
          want_result = pending_results.pop_front();
          if (got_result !== want_result) flag_result("mismatch", got_result, want_result);
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_report(input nfta_pkg::id_t id, input nfta_pkg::pos_t x,
                             input nfta_pkg::pos_t y);
    report_t r;
    r.agent = id;
    r.x = x;
    r.y = y;
    queued_reports = {queued_reports, r};
    reports_sent++;
    // wait for the beat to be taken so the predictor state is current
    wait (reports_taken == reports_sent);
  endtask

  // report at an offset from the agent's held tile, or somewhere near the field center if it holds none
  task automatic aim_report(input nfta_pkg::id_t id, input int dx, input int dy);
    int t;
    if (task_held[id]) begin
      t = task_tile[id];
      send_report(id, nfta_pkg::pos_t'(tile_center(t % GRID) + dx),
                  nfta_pkg::pos_t'(tile_center(t / GRID) + dy));
    end else begin
      send_report(id, nfta_pkg::pos_t'(int'($urandom_range(4000)) - 2000),
                  nfta_pkg::pos_t'(int'($urandom_range(4000)) - 2000));
    end
  endtask

  task automatic random_report();
    nfta_pkg::id_t id;
    int  pick;
    int  off;
    int  t;
    id = nfta_pkg::id_t'($urandom_range(AGENTS - 1));
    pick = $urandom_range(99);
    if (pick < 55) begin
      aim_report(id, int'($urandom_range(134)) - 67, int'($urandom_range(134)) - 67);
    end else if (pick < 65) begin
      // right at the edge of the reach circle
      off = $urandom_range(1) ? 96 : 95;
      if ($urandom_range(1)) off = -off;
      if ($urandom_range(1)) aim_report(id, off, 0);
      else aim_report(id, 0, off);
    end else if (pick < 80) begin
      t = $urandom_range(TILES - 1);
      send_report(id,
                  nfta_pkg::pos_t'(tile_center(t % GRID) + int'($urandom_range(4000)) - 2000),
                  nfta_pkg::pos_t'(tile_center(t / GRID) + int'($urandom_range(4000)) - 2000));
    end else begin
      send_report(id, nfta_pkg::pos_t'($urandom), nfta_pkg::pos_t'($urandom));
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // origin sits on the corner of four tiles
    send_report(0, 0, 0);
    send_report(1, 0, 0);
    // field extremes map onto the grid corners
    send_report(2, -16384, -16384);
    send_report(3, 16383, 16383);
    send_report(4, -16384, 16383);
    send_report(5, 16383, -16384);
    // reach test is strict
    aim_report(0, 96, 0);
    aim_report(0, 0, -96);
    aim_report(0, 95, 0);
    aim_report(1, 68, 68);
    aim_report(1, -67, 67);
    aim_report(2, 0, 0);
    aim_report(3, -95, 0);
    aim_report(4, 0, 95);
    // tie between two columns at the grid edge
    send_report(15, -7680, -7840);
    send_report(15, 0, 0);
    send_report(6, 16383, 0);
    send_report(7, -1, -1);
    wait (pending_results.size() == 0);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      repeat (PHASE_ITEMS) random_report();
      if (p == 0) begin
        // stall the output long enough for the block to back up its input
        holds_asked++;
        repeat (4) random_report();
      end
      wait (pending_results.size() == 0);
    end

    wait (pending_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d reports over four idle/stall mixes plus a long output hold-off", reports_taken);
    $display("%0d results, %0d tile reaches, %0d tiles covered, %0d failures",
             results_seen, reaches_seen, covered_total, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/nfta_pkg.sv
src/nfta_if.sv
src/nfta_ram.sv
src/nfta_mul.sv
src/nearest_free_tile_assigner.sv
src/nfta_chk.sv
sim/nearest_free_tile_assigner_test.sv
